// ----- sv/rfwr_pkg.sv -----
// Shared types, constants and saturation helper for the residual restriction block.
package rfwr_pkg;

   localparam int SAMPLE_W = 32;
   localparam int LAP_W = SAMPLE_W + 2;
   localparam int INV_W = 32;
   localparam int PROD_W = LAP_W + INV_W + 1;
   localparam int WIDE_W = 52;
   localparam int IDX_W = 11;
   localparam int FRAC_BITS = 16;

   localparam int DEFAULT_MAX_FINE_NODES = 4095;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [INV_W-1:0] INV_H2_RESET = 32'h0001_0000;

   localparam logic signed [WIDE_W-1:0] SAT_HI =
      {{(WIDE_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO =
      {{(WIDE_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      logic signed [LAP_W-1:0]    lap;
      logic signed [SAMPLE_W-1:0] f;
      logic                       emit;
      logic [IDX_W-1:0]           idx;
      logic                       last;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [WIDE_W-1:0] v
   );
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/rfwr_front.sv -----
// Front end: accepts fine nodes, keeps the node window and builds Laplacian entries.
module rfwr_front #(
   parameter int MAX_FINE_NODES = rfwr_pkg::DEFAULT_MAX_FINE_NODES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0]  req_y_value,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0]  req_f_value,
   input  logic                                  req_last_node,
   input  rfwr_pkg::queue_status_type            q_status,
   output logic                                  push,
   output rfwr_pkg::entry_type                   push_entry
);

   localparam int PW = $clog2(MAX_FINE_NODES + 1);

   logic [PW-1:0]                        pos_ff, pos_in;
   logic signed [rfwr_pkg::SAMPLE_W-1:0] y_back_one_ff, y_back_one_in;
   logic signed [rfwr_pkg::SAMPLE_W-1:0] y_back_two_ff, y_back_two_in;
   logic signed [rfwr_pkg::SAMPLE_W-1:0] f_back_one_ff, f_back_one_in;

   logic        accept;
   logic        in_window;
   logic [31:0] k_wide;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign k_wide    = 32'(pos_ff);
   assign in_window = k_wide < 32'(MAX_FINE_NODES);

   always_comb begin
      push_entry.lap  = $signed({{2{y_back_two_ff[rfwr_pkg::SAMPLE_W-1]}}, y_back_two_ff})
                      - $signed({y_back_one_ff[rfwr_pkg::SAMPLE_W-1], y_back_one_ff, 1'b0})
                      + $signed({{2{req_y_value[rfwr_pkg::SAMPLE_W-1]}}, req_y_value});
      push_entry.f    = f_back_one_ff;
      push_entry.emit = (k_wide >= 32'd4) && !pos_ff[0];
      push_entry.idx  = rfwr_pkg::IDX_W'((k_wide >> 1) - 32'd1);
      push_entry.last = req_last_node;
   end

   assign push = accept && in_window && (k_wide >= 32'd2);

   always_comb begin
      pos_in        = pos_ff;
      y_back_one_in = y_back_one_ff;
      y_back_two_in = y_back_two_ff;
      f_back_one_in = f_back_one_ff;
      if (accept) begin
         if (in_window) begin
            pos_in        = pos_ff + PW'(1);
            y_back_two_in = y_back_one_ff;
            y_back_one_in = req_y_value;
            f_back_one_in = req_f_value;
         end
         if (req_last_node) begin
            pos_in        = '0;
            y_back_one_in = '0;
            y_back_two_in = '0;
            f_back_one_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         y_back_one_ff <= '0;
         y_back_two_ff <= '0;
         f_back_one_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         y_back_one_ff <= y_back_one_in;
         y_back_two_ff <= y_back_two_in;
         f_back_one_ff <= f_back_one_in;
      end
   end

endmodule

// ----- sv/rfwr_queue.sv -----
// Short entry queue between the front end and the arithmetic back end.
module rfwr_queue #(
   parameter int DEPTH = rfwr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rfwr_pkg::entry_type        push_entry,
   input  logic                       pop,
   output rfwr_pkg::entry_type        head_entry,
   output rfwr_pkg::queue_status_type q_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rfwr_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign head_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/rfwr_back.sv -----
// Back end: scaled Laplacian, residual window and full-weighting output stage.
module rfwr_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rfwr_pkg::INV_W-1:0]            inv_h2,
   input  rfwr_pkg::queue_status_type            q_status,
   input  rfwr_pkg::entry_type                   head_entry,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rfwr_pkg::IDX_W-1:0]            rsp_coarse_index,
   output logic signed [rfwr_pkg::SAMPLE_W-1:0]  rsp_coarse_rhs,
   output logic                                  rsp_last_out
);

   localparam int SW = rfwr_pkg::SAMPLE_W;
   localparam int PW = rfwr_pkg::PROD_W;
   localparam int WW = rfwr_pkg::WIDE_W;
   localparam logic signed [PW-1:0] ROUND_Q16 = PW'(32768);

   logic                      advance;

   logic                      a_valid_ff, a_valid_in;
   rfwr_pkg::entry_type       a_entry_ff, a_entry_in;

   logic                      b_valid_ff, b_valid_in;
   logic signed [PW-1:0]      b_prod_ff, b_prod_in;
   logic signed [SW-1:0]      b_f_ff, b_f_in;
   logic                      b_emit_ff, b_emit_in;
   logic [rfwr_pkg::IDX_W-1:0] b_idx_ff, b_idx_in;
   logic                      b_last_ff, b_last_in;

   logic                      c_valid_ff, c_valid_in;
   logic signed [SW-1:0]      c_resid_ff, c_resid_in;
   logic                      c_emit_ff, c_emit_in;
   logic [rfwr_pkg::IDX_W-1:0] c_idx_ff, c_idx_in;
   logic                      c_last_ff, c_last_in;

   logic signed [SW-1:0]      resid_one_ff, resid_one_in;
   logic signed [SW-1:0]      resid_two_ff, resid_two_in;

   logic                      out_valid_ff, out_valid_in;
   logic [rfwr_pkg::IDX_W-1:0] out_idx_ff, out_idx_in;
   logic signed [SW-1:0]      out_rhs_ff, out_rhs_in;
   logic                      out_last_ff, out_last_in;

   logic signed [PW-1:0]      rounded;
   logic signed [PW-1:0]      shifted;
   logic signed [WW-1:0]      diff;
   logic signed [SW+2:0]      wsum;
   logic signed [SW+2:0]      wscaled;

   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   assign rounded = b_prod_ff + ROUND_Q16;
   assign shifted = rounded >>> rfwr_pkg::FRAC_BITS;
   assign diff    = $signed({{(WW-SW){b_f_ff[SW-1]}}, b_f_ff}) - shifted[WW-1:0];

   assign wsum    = $signed({{3{resid_two_ff[SW-1]}}, resid_two_ff})
                  + $signed({{2{resid_one_ff[SW-1]}}, resid_one_ff, 1'b0})
                  + $signed({{3{c_resid_ff[SW-1]}}, c_resid_ff});
   assign wscaled = (wsum + (SW+3)'(2)) >>> 2;

   always_comb begin
      a_valid_in   = a_valid_ff;
      a_entry_in   = a_entry_ff;
      b_valid_in   = b_valid_ff;
      b_prod_in    = b_prod_ff;
      b_f_in       = b_f_ff;
      b_emit_in    = b_emit_ff;
      b_idx_in     = b_idx_ff;
      b_last_in    = b_last_ff;
      c_valid_in   = c_valid_ff;
      c_resid_in   = c_resid_ff;
      c_emit_in    = c_emit_ff;
      c_idx_in     = c_idx_ff;
      c_last_in    = c_last_ff;
      resid_one_in = resid_one_ff;
      resid_two_in = resid_two_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_rhs_in   = out_rhs_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         a_valid_in = pop;
         if (pop) begin
            a_entry_in = head_entry;
         end
         b_valid_in = a_valid_ff;
         b_prod_in  = $signed({{(PW-rfwr_pkg::LAP_W){a_entry_ff.lap[rfwr_pkg::LAP_W-1]}},
                               a_entry_ff.lap})
                    * $signed({{(PW-rfwr_pkg::INV_W){1'b0}}, inv_h2});
         b_f_in     = a_entry_ff.f;
         b_emit_in  = a_entry_ff.emit;
         b_idx_in   = a_entry_ff.idx;
         b_last_in  = a_entry_ff.last;
         c_valid_in = b_valid_ff;
         c_resid_in = rfwr_pkg::sat_sample(diff);
         c_emit_in  = b_emit_ff;
         c_idx_in   = b_idx_ff;
         c_last_in  = b_last_ff;
         out_valid_in = c_valid_ff && c_emit_ff;
         out_idx_in   = c_idx_ff;
         out_rhs_in   = rfwr_pkg::sat_sample(
                           $signed({{(WW-SW-3){wscaled[SW+2]}}, wscaled}));
         out_last_in  = c_last_ff;
         if (c_valid_ff) begin
            resid_two_in = resid_one_ff;
            resid_one_in = c_resid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_entry_ff   <= a_entry_in;
      b_prod_ff    <= b_prod_in;
      b_f_ff       <= b_f_in;
      b_emit_ff    <= b_emit_in;
      b_idx_ff     <= b_idx_in;
      b_last_ff    <= b_last_in;
      c_resid_ff   <= c_resid_in;
      c_emit_ff    <= c_emit_in;
      c_idx_ff     <= c_idx_in;
      c_last_ff    <= c_last_in;
      resid_one_ff <= resid_one_in;
      resid_two_ff <= resid_two_in;
      out_idx_ff   <= out_idx_in;
      out_rhs_ff   <= out_rhs_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_coarse_index = out_idx_ff;
   assign rsp_coarse_rhs   = out_rhs_ff;
   assign rsp_last_out     = out_last_ff;

endmodule

// ----- sv/residual_full_weighting_restrict_1d.sv -----
// Top level of the streaming 1D residual and full-weighting restriction block.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   y_value, f_value, last_node
//   rsp_      out        rsp_valid / rsp_stall   coarse_index, coarse_rhs, last_out
//   csr_      in         csr_write_enable        csr_write_data (inv_h2)
//
// One fine node is accepted per cycle while the queue is not full; a coarse value is
// built from the node that causes it in the queue, multiply, residual and weighting stages.
// The 34 x 33 bit Laplacian multiply sits alone between two registers.
// Reset clears the window, the queue and the pipeline valids; inv_h2 returns to 1.0.
// rsp_stall holds the back end; the queue keeps taking items until it is full.
module residual_full_weighting_restrict_1d #(
   parameter int MAX_FINE_NODES = rfwr_pkg::DEFAULT_MAX_FINE_NODES,
   parameter int QUEUE_DEPTH    = rfwr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0]  req_y_value,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0]  req_f_value,
   input  logic                                  req_last_node,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rfwr_pkg::IDX_W-1:0]            rsp_coarse_index,
   output logic signed [rfwr_pkg::SAMPLE_W-1:0]  rsp_coarse_rhs,
   output logic                                  rsp_last_out,
   input  logic                                  csr_write_enable,
   input  logic [rfwr_pkg::INV_W-1:0]            csr_write_data
);

   logic [rfwr_pkg::INV_W-1:0] inv_h2_ff, inv_h2_in;

   logic                       push;
   logic                       pop;
   rfwr_pkg::entry_type        push_entry;
   rfwr_pkg::entry_type        head_entry;
   rfwr_pkg::queue_status_type q_status;

   assign inv_h2_in = csr_write_enable ? csr_write_data : inv_h2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_h2_ff <= rfwr_pkg::INV_H2_RESET;
      end else begin
         inv_h2_ff <= inv_h2_in;
      end
   end

   rfwr_front #(
      .MAX_FINE_NODES(MAX_FINE_NODES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_y_value  (req_y_value),
      .req_f_value  (req_f_value),
      .req_last_node(req_last_node),
      .q_status     (q_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   rfwr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .q_status  (q_status)
   );

   rfwr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .inv_h2          (inv_h2_ff),
      .q_status        (q_status),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coarse_index(rsp_coarse_index),
      .rsp_coarse_rhs  (rsp_coarse_rhs),
      .rsp_last_out    (rsp_last_out)
   );

   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> (req_valid && !req_stall))
      else $error("queue push without an accepted item");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue reports empty and full at once");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!req_stall && !rsp_valid))
      else $error("block not idle after reset");

endmodule

// ----- bench/rfwr_restrict_checker.sv -----
// Channel monitor that predicts coarse restricted items and compares them with the block.
module rfwr_restrict_checker #(
   parameter int MAX_FINE_NODES = rfwr_pkg::DEFAULT_MAX_FINE_NODES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0] req_y_value,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0] req_f_value,
   input  logic                                 req_last_node,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [rfwr_pkg::IDX_W-1:0]           rsp_coarse_index,
   input  logic signed [rfwr_pkg::SAMPLE_W-1:0] rsp_coarse_rhs,
   input  logic                                 rsp_last_out,
   input  logic                                 csr_write_enable,
   input  logic [rfwr_pkg::INV_W-1:0]           csr_write_data,
   output int                                   error_count,
   output int                                   outstanding
);

   localparam int SAMPLE_W  = rfwr_pkg::SAMPLE_W;
   localparam int IDX_W     = rfwr_pkg::IDX_W;
   localparam int INV_W     = rfwr_pkg::INV_W;
   localparam int FRAC_BITS = rfwr_pkg::FRAC_BITS;

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   typedef struct packed {
      logic [IDX_W-1:0]           index;
      logic signed [SAMPLE_W-1:0] rhs;
      logic                       last;
   } coarse_item_type;

   coarse_item_type            coarse_due[$];
   coarse_item_type            due_item;
   logic [INV_W-1:0]           inv_h2;
   logic signed [SAMPLE_W-1:0] y_prev1, y_prev2, f_prev1, r_prev1, r_prev2;
   int unsigned                node_pos;
   int                         err_total = 0;
   int                         due_count = 0;

   assign error_count = err_total;
   assign outstanding = due_count;

   function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
      if (v > SAMPLE_MAX) begin
         return SAMPLE_MAX[SAMPLE_W-1:0];
      end else if (v < SAMPLE_MIN) begin
         return SAMPLE_MIN[SAMPLE_W-1:0];
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] node_residual(
      input logic signed [SAMPLE_W-1:0] f_mid,
      input logic signed [SAMPLE_W-1:0] y_left,
      input logic signed [SAMPLE_W-1:0] y_mid,
      input logic signed [SAMPLE_W-1:0] y_right
   );
      longint lap, hi_part, lo_part, term;
      lap = longint'(y_left) - 2 * longint'(y_mid) + longint'(y_right);
      hi_part = longint'(inv_h2[INV_W-1:FRAC_BITS]);
      lo_part = longint'(inv_h2[FRAC_BITS-1:0]);
      term = lap * hi_part + ((lap * lo_part + 32768) >>> FRAC_BITS);
      return clamp_sample(longint'(f_mid) - term);
   endfunction

   function automatic void clear_window();
      y_prev1 = '0;
      y_prev2 = '0;
      f_prev1 = '0;
      r_prev1 = '0;
      r_prev2 = '0;
      node_pos = 0;
   endfunction

   function automatic void restrict_node(
      input logic signed [SAMPLE_W-1:0] y,
      input logic signed [SAMPLE_W-1:0] f,
      input logic                       last
   );
      int unsigned                k;
      logic signed [SAMPLE_W-1:0] r_new;
      longint                     sum;
      coarse_item_type            item;
      k = node_pos;
      if (k < MAX_FINE_NODES) begin
         r_new = '0;
         if (k >= 2) begin
            r_new = node_residual(f_prev1, y_prev2, y_prev1, y);
         end
         if (k >= 4 && (k % 2) == 0) begin
            sum = longint'(r_prev2) + 2 * longint'(r_prev1) + longint'(r_new);
            item.index = IDX_W'(k / 2 - 1);
            item.rhs = clamp_sample((sum + 2) >>> 2);
            item.last = last;
            coarse_due.push_back(item);
         end
         if (k >= 2) begin
            r_prev2 = r_prev1;
            r_prev1 = r_new;
         end
         y_prev2 = y_prev1;
         y_prev1 = y;
         f_prev1 = f;
         node_pos = k + 1;
      end
      if (last) begin
         clear_window();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         coarse_due.delete();
         inv_h2 = rfwr_pkg::INV_H2_RESET;
         clear_window();
      end else begin
         if (csr_write_enable) begin
            inv_h2 = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            restrict_node(req_y_value, req_f_value, req_last_node);
         end
         if (rsp_valid && !rsp_stall) begin
            if (coarse_due.size() == 0) begin
               $error("unexpected item: coarse_index %0d coarse_rhs %0d last_out %0b",
                      rsp_coarse_index, rsp_coarse_rhs, rsp_last_out);
               err_total++;
            end else begin
               due_item = coarse_due.pop_front();
               if (rsp_coarse_index !== due_item.index) begin
                  $error("coarse_index: expected %0d, actual %0d",
                         due_item.index, rsp_coarse_index);
                  err_total++;
               end
               if (rsp_coarse_rhs !== due_item.rhs) begin
                  $error("coarse_rhs: expected %0d, actual %0d",
                         due_item.rhs, rsp_coarse_rhs);
                  err_total++;
               end
               if (rsp_last_out !== due_item.last) begin
                  $error("last_out: expected %0b, actual %0b",
                         due_item.last, rsp_last_out);
                  err_total++;
               end
            end
         end
      end
      due_count <= coarse_due.size();
   end

endmodule

// ----- bench/tb_residual_full_weighting_restrict_1d.sv -----
// Stimulus and verdict for the residual restriction block, with the checker beside it.
module tb_residual_full_weighting_restrict_1d;

   localparam int SAMPLE_W = rfwr_pkg::SAMPLE_W;
   localparam int IDX_W    = rfwr_pkg::IDX_W;
   localparam int INV_W    = rfwr_pkg::INV_W;

   localparam int HOLD_CYCLES    = 160;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 12;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_y_value = '0;
   logic signed [SAMPLE_W-1:0] req_f_value = '0;
   logic                       req_last_node = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [IDX_W-1:0]           rsp_coarse_index;
   logic signed [SAMPLE_W-1:0] rsp_coarse_rhs;
   logic                       rsp_last_out;
   logic                       csr_write_enable = 1'b0;
   logic [INV_W-1:0]           csr_write_data = '0;

   int   error_count;
   int   outstanding;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_token = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   always #4 clock = ~clock;

   residual_full_weighting_restrict_1d DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_y_value      (req_y_value),
      .req_f_value      (req_f_value),
      .req_last_node    (req_last_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coarse_index (rsp_coarse_index),
      .rsp_coarse_rhs   (rsp_coarse_rhs),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rfwr_restrict_checker restrict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_y_value      (req_y_value),
      .req_f_value      (req_f_value),
      .req_last_node    (req_last_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coarse_index (rsp_coarse_index),
      .rsp_coarse_rhs   (rsp_coarse_rhs),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   // hold off for a long stretch when asked, else stall at random
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_node(
      input logic signed [SAMPLE_W-1:0] y,
      input logic signed [SAMPLE_W-1:0] f,
      input logic                       last
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_y_value <= y;
      req_f_value <= f;
      req_last_node <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_inv_h2(input logic [INV_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return SAMPLE_TOP;
         1: return SAMPLE_BOTTOM;
         2: return '0;
         3, 4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [INV_W-1:0] pick_inv_h2();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return rfwr_pkg::INV_H2_RESET;
         3: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_grid_length();
      case ($urandom_range(9))
         0: return $urandom_range(1, 4);
         1: return $urandom_range(41, 120);
         default: return $urandom_range(5, 40);
      endcase
   endfunction

   task automatic send_grid(input int nodes);
      for (int n = 0; n < nodes; n++) begin
         send_node(pick_sample(), pick_sample(), n == nodes - 1);
      end
   endtask

   task automatic run_phase(
      input int sender_pct,
      input int receiver_pct,
      input int node_budget,
      input bit with_hold
   );
      int sent;
      int len;
      send_idle_pct = sender_pct;
      recv_stall_pct <= receiver_pct;
      sent = 0;
      if (with_hold) begin
         hold_token <= ~hold_token;
         send_grid(40);
         sent = 40;
         drain();
      end
      while (sent < node_budget) begin
         if ($urandom_range(5) == 0) begin
            drain();
            write_inv_h2(pick_inv_h2());
         end
         len = pick_grid_length();
         send_grid(len);
         sent += len;
      end
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-node grid, a grid that ends before index four, then one that ends on index four
      send_node(SAMPLE_TOP, SAMPLE_BOTTOM, 1'b1);
      send_node(SAMPLE_BOTTOM, SAMPLE_TOP, 1'b0);
      send_node(SAMPLE_TOP, '0, 1'b0);
      send_node(SAMPLE_BOTTOM, SAMPLE_BOTTOM, 1'b1);
      for (int n = 0; n < 5; n++) begin
         send_node(n % 2 ? SAMPLE_BOTTOM : SAMPLE_TOP,
                   n % 2 ? SAMPLE_TOP : SAMPLE_BOTTOM, n == 4);
      end
      // end the grid on an odd index
      for (int n = 0; n < 6; n++) begin
         send_node(SAMPLE_W'(n * 32'h0001_8000), SAMPLE_W'(-n * 32'h0000_4000), n == 5);
      end
      drain();
      write_inv_h2('1);
      for (int n = 0; n < 5; n++) begin
         send_node(n % 2 ? SAMPLE_BOTTOM : SAMPLE_TOP, SAMPLE_TOP, n == 4);
      end
      drain();
      write_inv_h2('0);
      for (int n = 0; n < 5; n++) begin
         send_node(SAMPLE_TOP, n % 2 ? SAMPLE_BOTTOM : SAMPLE_TOP, n == 4);
      end
      drain();

      run_phase(19, 54, 600, 1'b1);
      run_phase(54, 19, 600, 1'b0);
      run_phase(0, 0, 600, 1'b0);

      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
